// ===== hdl/atl_pkg.sv =====
// shared types, constants and character classes for the assembly token lexer
// no dependencies; imported by every module of the block
package atl_pkg;

    // scanner mode codes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_NUM     = 3'd1;
    localparam logic [2:0] MODE_IDENT   = 3'd2;
    localparam logic [2:0] MODE_SEMI    = 3'd3;
    localparam logic [2:0] MODE_COMMENT = 3'd4;

    // token kinds
    localparam logic [1:0] KIND_INT   = 2'd0;
    localparam logic [1:0] KIND_FLOAT = 2'd1;
    localparam logic [1:0] KIND_IDENT = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // character constants
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // position limits
    localparam logic [19:0] MAX_LINE   = 20'hFFFFF;
    localparam logic [15:0] MAX_COLUMN = 16'hFFFF;
    localparam logic [15:0] MAX_LENGTH = 16'hFFFF;

    // largest file size; the offset saturates at the smaller of this less one and 20 bits
    localparam longint unsigned MAX_INPUT_BYTES = 64'd1048576;
    localparam longint unsigned OFF_LIMIT = (MAX_INPUT_BYTES - 64'd1 > 64'hFFFFF) ?
                                            64'hFFFFF : (MAX_INPUT_BYTES - 64'd1);
    localparam logic [19:0] MAX_OFFSET = OFF_LIMIT[19:0];

    // depth of the token queue between scanner and output stage
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] line;
        logic [15:0] column;
        logic [19:0] offset;
        logic [15:0] length;
    } t_token;

    // tokens caused by one character: one, or two when two is set
    typedef struct packed {
        t_token tok0;
        t_token tok1;
        logic   two;
    } t_entry;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == CH_UNDER);
    endfunction

endpackage

// ===== hdl/atl_front.sv =====
// scanner: takes one character a cycle while i_accept is high, tracks position and mode, builds token entries
// depends on atl_pkg
module atl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_char_code,
    input  logic            i_end_of_file,
    output logic            o_push,
    output atl_pkg::t_entry o_entry
);
    import atl_pkg::*;

    logic [2:0]  r_mode, n_mode;
    logic        r_dot, n_dot;
    logic [15:0] r_len, n_len;
    logic [19:0] r_line, n_line;
    logic [15:0] r_col, n_col;
    logic [19:0] r_off, n_off;
    logic [19:0] r_sl, n_sl;
    logic [15:0] r_sc, n_sc;
    logic [19:0] r_so, n_so;

    logic        e0, e1, rescan;
    logic [1:0]  k0, k1;
    t_token      t0, t1;

    // mode update for one character
    always_comb begin
        n_mode = r_mode;
        n_dot  = r_dot;
        n_len  = r_len;
        n_sl   = r_sl;
        n_sc   = r_sc;
        n_so   = r_so;
        e0     = 1'b0;
        k0     = KIND_INT;
        rescan = 1'b0;
        unique case (r_mode)
            MODE_NUM: begin
                if (is_digit(i_char_code)) begin
                    if (r_len != MAX_LENGTH) n_len = r_len + 16'd1;
                end else if (i_char_code == CH_DOT) begin
                    if (r_dot) begin
                        e0     = 1'b1;
                        k0     = KIND_ERR;
                        n_mode = MODE_IDLE;
                    end else begin
                        n_dot = 1'b1;
                        if (r_len != MAX_LENGTH) n_len = r_len + 16'd1;
                    end
                end else begin
                    e0     = 1'b1;
                    k0     = r_dot ? KIND_FLOAT : KIND_INT;
                    rescan = 1'b1;
                end
            end
            MODE_IDENT: begin
                if (is_word(i_char_code)) begin
                    if (r_len != MAX_LENGTH) n_len = r_len + 16'd1;
                end else begin
                    e0     = 1'b1;
                    k0     = KIND_IDENT;
                    rescan = 1'b1;
                end
            end
            MODE_SEMI: begin
                if (i_char_code == CH_SEMI) n_mode = MODE_COMMENT;
                else rescan = 1'b1;
            end
            MODE_COMMENT: begin
                if (i_char_code == CH_NEWLINE) n_mode = MODE_IDLE;
            end
            default: begin
                rescan = 1'b1;
            end
        endcase

        // character handled afresh: may open a token or a comment
        if (rescan) begin
            n_mode = MODE_IDLE;
            if (is_digit(i_char_code) || is_word(i_char_code)) begin
                n_mode = is_digit(i_char_code) ? MODE_NUM : MODE_IDENT;
                n_dot  = 1'b0;
                n_len  = 16'd1;
                n_sl   = r_line;
                n_sc   = r_col;
                n_so   = r_off;
            end else if (i_char_code == CH_SEMI) begin
                n_mode = MODE_SEMI;
            end
        end
    end

    // position update, saturating
    always_comb begin
        n_line = r_line;
        n_col  = r_col;
        n_off  = r_off;
        if (i_char_code == CH_NEWLINE) begin
            n_col = 16'd0;
            if (r_line < MAX_LINE) n_line = r_line + 20'd1;
        end else if (r_col < MAX_COLUMN) begin
            n_col = r_col + 16'd1;
        end
        if (r_off < MAX_OFFSET) n_off = r_off + 20'd1;
    end

    // token closed by end of file
    always_comb begin
        e1 = i_end_of_file && ((n_mode == MODE_NUM) || (n_mode == MODE_IDENT));
        if (n_mode == MODE_IDENT) k1 = KIND_IDENT;
        else k1 = n_dot ? KIND_FLOAT : KIND_INT;
    end

    // entry assembly
    always_comb begin
        t0 = '{kind: k0, line: r_sl, column: r_sc, offset: r_so, length: r_len};
        t1 = '{kind: k1, line: n_sl, column: n_sc, offset: n_so, length: n_len};
        if (e0) begin
            o_entry.tok0 = t0;
            o_entry.tok1 = t1;
            o_entry.two  = e1;
        end else begin
            o_entry.tok0 = t1;
            o_entry.tok1 = t1;
            o_entry.two  = 1'b0;
        end
        o_push = i_accept && (e0 || e1);
    end

    // scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_end_of_file)) begin
            r_mode <= MODE_IDLE;
            r_dot  <= 1'b0;
            r_len  <= 16'd0;
            r_line <= 20'd0;
            r_col  <= 16'd0;
            r_off  <= 20'd0;
            r_sl   <= 20'd0;
            r_sc   <= 16'd0;
            r_so   <= 20'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_dot  <= n_dot;
            r_len  <= n_len;
            r_line <= n_line;
            r_col  <= n_col;
            r_off  <= n_off;
            r_sl   <= n_sl;
            r_sc   <= n_sc;
            r_so   <= n_so;
        end
    end

endmodule

// ===== hdl/atl_queue.sv =====
// short queue of token entries between scanner and output stage
// depends on atl_pkg
module atl_queue #(
    parameter int DEPTH = atl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  atl_pkg::t_entry i_data,
    input  logic            i_pop,
    output atl_pkg::t_entry o_data,
    output logic            o_full,
    output logic            o_empty
);
    import atl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    t_entry        r_store [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_store[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_store[r_wr] <= i_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            if (do_pop) r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            if (do_push && !do_pop) r_cnt <= r_cnt + CW'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

// ===== hdl/atl_back.sv =====
// output stage: splits queue entries into single tokens in an output register
// depends on atl_pkg
module atl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  atl_pkg::t_entry i_head,
    input  logic            i_empty,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output atl_pkg::t_token o_token,
    output logic            o_last
);
    import atl_pkg::*;

    logic   r_valid;
    logic   r_sub;
    t_token r_token;
    logic   r_last;
    logic   load, fin;

    // load when the register is free or its word is taken
    assign load    = !i_empty && (!r_valid || !i_stall);
    assign fin     = r_sub || !i_head.two;
    assign o_pop   = load && fin;
    assign o_valid = r_valid;
    assign o_token = r_token;
    assign o_last  = r_last;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= !fin;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_token <= r_sub ? i_head.tok1 : i_head.tok0;
            r_last  <= fin;
        end
    end

endmodule

// ===== hdl/asm_token_lexer.sv =====
// top level of the assembly token lexer: scanner, token queue and output stage
// depends on atl_pkg, atl_front, atl_queue and atl_back
//
// One character word is taken each cycle while o_stall is low; o_stall rises only
// when the token queue is full. A character that ends one token and closes another
// at end of file gives two tokens, which leave the output register one after the other, so the
// output side sets the sustained rate only when such characters come close together.
// A token appears on the output at the clock edge after the one that takes the
// character completing it, or later if i_stall holds the output register. Whitespace,
// lone semicolons, ";;" comments up to the newline and unknown characters give no token.
// Positions count from zero; column and length saturate at 65535, line at 1048575.
module asm_token_lexer #(
    parameter int QUEUE_DEPTH = atl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_token_kind,
    output logic [19:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic [19:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);
    import atl_pkg::*;

    logic   accept, push, pop, full, empty;
    t_entry push_entry, head;
    t_token token;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    // scanner
    atl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_char_code   (i_char_code),
        .i_end_of_file (i_end_of_file),
        .o_push        (push),
        .o_entry       (push_entry)
    );

    // token queue
    atl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    // output stage
    atl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_token (token),
        .o_last  (o_last_of_run)
    );

    assign o_token_kind   = token.kind;
    assign o_start_line   = token.line;
    assign o_start_column = token.column;
    assign o_start_offset = token.offset;
    assign o_token_length = token.length;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// testbench for asm_token_lexer: random and directed character streams with a token predictor
// depends on atl_pkg and asm_token_lexer

module tb;
    import atl_pkg::*;

    localparam int CHAR_COUNT   = 1700;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] ch;
        logic       eof;
    } t_char_word;

    typedef struct packed {
        t_token tok;
        logic   last;
    } t_token_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_char_code = 8'd0;
    logic        i_end_of_file = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_token_kind;
    logic [19:0] o_start_line;
    logic [15:0] o_start_column;
    logic [19:0] o_start_offset;
    logic [15:0] o_token_length;
    logic        o_last_of_run;

    t_char_word  pending_chars[$];
    t_token_word expected_tokens[$];

    // lexer state as seen by the predictor
    logic [2:0]  lex_mode;
    logic        in_float;
    logic [19:0] pos_line;
    logic [15:0] pos_col;
    logic [19:0] pos_off;
    logic [19:0] tok_line;
    logic [15:0] tok_col;
    logic [19:0] tok_off;
    logic [15:0] tok_len;
    t_token      step_toks[2];
    int          step_n;

    int  mismatch_count = 0;
    int  chars_taken = 0;
    int  quiet_cycles = 0;
    bit  char_taken = 1'b0;
    bit  calm = 1'b0;

    asm_token_lexer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_end_of_file  (i_end_of_file),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_start_line   (o_start_line),
        .o_start_column (o_start_column),
        .o_start_offset (o_start_offset),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // character classes
    function automatic bit digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic void clear_lexer();
        lex_mode = MODE_IDLE;
        in_float = 1'b0;
        pos_line = '0;
        pos_col  = '0;
        pos_off  = '0;
        tok_line = '0;
        tok_col  = '0;
        tok_off  = '0;
        tok_len  = '0;
    endfunction

    function automatic void emit_token(input logic [1:0] kind);
        if (step_n < 2) begin
            step_toks[step_n] = '{kind: kind, line: tok_line, column: tok_col,
                                  offset: tok_off, length: tok_len};
            step_n++;
        end
    endfunction

    function automatic void open_token(input logic [2:0] m);
        lex_mode = m;
        in_float = 1'b0;
        tok_len  = 16'd1;
        tok_line = pos_line;
        tok_col  = pos_col;
        tok_off  = pos_off;
    endfunction

    function automatic void bump_length();
        if (tok_len < MAX_LENGTH) tok_len++;
    endfunction

    function automatic void close_open_token();
        if (lex_mode == MODE_NUM)
            emit_token(in_float ? KIND_FLOAT : KIND_INT);
        else if (lex_mode == MODE_IDENT)
            emit_token(KIND_IDENT);
        lex_mode = MODE_IDLE;
    endfunction

    function automatic void scan_fresh(input logic [7:0] c);
        lex_mode = MODE_IDLE;
        if (digit_char(c))
            open_token(MODE_NUM);
        else if (word_char(c))
            open_token(MODE_IDENT);
        else if (c == CH_SEMI)
            lex_mode = MODE_SEMI;
    endfunction

    // works out the tokens one accepted character gives and queues them
    function automatic void predict_tokens(input logic [7:0] c, input logic eof);
        step_n = 0;
        case (lex_mode)
            MODE_NUM: begin
                if (digit_char(c)) begin
                    bump_length();
                end else if (c == CH_DOT) begin
                    if (in_float) begin
                        emit_token(KIND_ERR);
                        lex_mode = MODE_IDLE;
                    end else begin
                        in_float = 1'b1;
                        bump_length();
                    end
                end else begin
                    close_open_token();
                    scan_fresh(c);
                end
            end
            MODE_IDENT: begin
                if (word_char(c)) begin
                    bump_length();
                end else begin
                    close_open_token();
                    scan_fresh(c);
                end
            end
            MODE_SEMI: begin
                if (c == CH_SEMI) lex_mode = MODE_COMMENT;
                else scan_fresh(c);
            end
            MODE_COMMENT: begin
                if (c == CH_NEWLINE) lex_mode = MODE_IDLE;
            end
            default: scan_fresh(c);
        endcase

        // position after the character, saturating
        if (c == CH_NEWLINE) begin
            pos_col = '0;
            if (pos_line < MAX_LINE) pos_line++;
        end else if (pos_col < MAX_COLUMN) begin
            pos_col++;
        end
        if (pos_off < MAX_OFFSET) pos_off++;

        if (eof) begin
            close_open_token();
            clear_lexer();
        end

        for (int k = 0; k < step_n; k++)
            expected_tokens.push_back('{tok: step_toks[k], last: (k == step_n - 1)});
    endfunction

    function automatic void check_field(input string name, input logic [19:0] want,
                                        input logic [19:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // stimulus helpers
    function automatic void add_char(input logic [7:0] ch, input logic eof);
        pending_chars.push_back('{ch: ch, eof: eof});
    endfunction

    function automatic void add_text(input string s, input logic eof_last);
        for (int k = 0; k < s.len(); k++)
            add_char(s[k], eof_last && (k == s.len() - 1));
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(52);
        if (r < 26) return 8'(("a") + r);
        if (r < 52) return 8'(("A") + r - 26);
        return CH_UNDER;
    endfunction

    function automatic void add_digits(input int n);
        for (int k = 0; k < n; k++)
            add_char(8'(("0") + $urandom_range(9)), 1'b0);
    endfunction

    // one random lexeme, mostly well formed, some noise
    function automatic void add_lexeme();
        int pick;
        int n;
        logic [7:0] ch;
        pick = $urandom_range(99);
        if (pick < 18) begin
            add_digits($urandom_range(1, 6));
        end else if (pick < 30) begin
            add_digits($urandom_range(1, 4));
            add_char(CH_DOT, 1'b0);
            add_digits($urandom_range(0, 4));
        end else if (pick < 36) begin
            add_digits($urandom_range(1, 3));
            add_char(CH_DOT, 1'b0);
            add_digits($urandom_range(0, 3));
            add_char(CH_DOT, 1'b0);
            add_digits($urandom_range(0, 2));
        end else if (pick < 56) begin
            n = $urandom_range(1, 8);
            for (int k = 0; k < n; k++)
                add_char(rand_word_char(), 1'b0);
        end else if (pick < 72) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
                ch = 8'($urandom_range(9, 14));
                add_char(ch == 8'd14 ? 8'd32 : ch, 1'b0);
            end
        end else if (pick < 78) begin
            add_text(";;", 1'b0);
            n = $urandom_range(0, 8);
            for (int k = 0; k < n; k++) begin
                do ch = 8'($urandom_range(255)); while (ch == CH_NEWLINE);
                add_char(ch, 1'b0);
            end
            add_char(CH_NEWLINE, 1'b0);
        end else if (pick < 83) begin
            add_char(CH_SEMI, 1'b0);
        end else if (pick < 90) begin
            case ($urandom_range(3))
                0: ch = CH_DOT;
                1: ch = 8'($urandom_range(33, 47));
                2: ch = 8'($urandom_range(128, 255));
                default: ch = 8'($urandom_range(0, 8));
            endcase
            add_char(ch, 1'b0);
        end else begin
            add_char(8'($urandom_range(255)), 1'b0);
        end
    endfunction

    // driver: new word at the falling edge once the last one has gone
    always @(negedge i_clk) begin : drive_chars
        t_char_word nxt;
        if (i_rst_n) begin
            if (!i_valid || char_taken) begin
                if (pending_chars.size() > 0 && (calm || $urandom_range(99) >= 20)) begin
                    nxt = pending_chars.pop_front();
                    i_valid       <= 1'b1;
                    i_char_code   <= nxt.ch;
                    i_end_of_file <= nxt.eof;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= !calm && ($urandom_range(99) < 20);
        end
    end

    // monitor: acceptance on both sides, token check and watchdog
    always @(posedge i_clk) begin : watch_ports
        t_token_word want;
        char_taken = i_rst_n && i_valid && !o_stall;
        if (char_taken) begin
            predict_tokens(i_char_code, i_end_of_file);
            chars_taken++;
        end
        calm = chars_taken >= 600 && chars_taken < 1000;

        if (i_rst_n && o_valid && !i_stall) begin
            quiet_cycles = 0;
            if (expected_tokens.size() == 0) begin
                $error("unexpected token word, kind %0d offset %0d",
                       o_token_kind, o_start_offset);
                mismatch_count++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", 20'(want.tok.kind), 20'(o_token_kind));
                check_field("start_line", want.tok.line, o_start_line);
                check_field("start_column", 20'(want.tok.column), 20'(o_start_column));
                check_field("start_offset", want.tok.offset, o_start_offset);
                check_field("token_length", 20'(want.tok.length), 20'(o_token_length));
                check_field("last_of_run", 20'(want.last), 20'(o_last_of_run));
            end
        end else if (char_taken) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end

        if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        int n_lex;
        clear_lexer();

        // directed: all token kinds, whitespace, lone semicolon, comment, second dot,
        // unknown and extreme codes, and end of file closing a token that just began
        add_text("09.5 A_z;q;;c\n1.2.3", 1'b0);
        add_char(8'h0B, 1'b0);
        add_char(8'h00, 1'b0);
        add_char(8'h80, 1'b0);
        add_char(8'hFF, 1'b0);
        add_char(CH_DOT, 1'b0);
        add_text("x5", 1'b1);

        // random files, each closed by end of file on its last character
        while (pending_chars.size() < CHAR_COUNT) begin
            n_lex = $urandom_range(1, 12);
            for (int k = 0; k < n_lex; k++)
                add_lexeme();
            if ($urandom_range(9) == 0)
                add_char(8'($urandom_range(255)), 1'b1);
            else
                pending_chars[$].eof = 1'b1;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || i_valid)
            @(negedge i_clk);
        while (expected_tokens.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && expected_tokens.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
